@@ rtl/pra_pkg.sv @@
// ----------------------------------------------------------------------------
// pra_pkg
// Shared types and constants of the page run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

  // Default page capacity and the page count after reset
  localparam int MAX_PAGES_DEF    = 1024;
  localparam int PAGE_COUNT_RESET = 1024;

  // Operation codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;
  localparam logic [1:0] ST_NOT_USED = 2'd3;

  // Request word
  typedef struct packed {
    logic        cmd;
    logic [10:0] count;
    logic [9:0]  start_page;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  page;
    logic [10:0] run_length;
  } out_word_t;

  // Page table read address select
  typedef enum logic [1:0] {
    RD_IDX   = 2'd0,
    RD_START = 2'd1,
    RD_TO    = 2'd2,
    RD_PREV  = 2'd3
  } rd_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       clr_step;
    rd_sel_t    rd_sel;
    logic       a_adv;
    logic       a_take;
    logic       f_chk0;
    logic       f_add_next;
    logic       f_prev;
    logic       wr_step;
    logic       res_set;
    logic [1:0] res_status;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic cnt_zero;
    logic sp_bad;
    logic idx_end;
    logic fit;
    logic f_unused;
    logic wr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/pra_datapath.sv @@
// ----------------------------------------------------------------------------
// pra_datapath
// Page table memories, scan and write pointers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_datapath #(
  parameter int MAX_PAGES = pra_pkg::MAX_PAGES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [10:0]       cfg_wdata,
  input  wire pra_pkg::in_word_t in_data,
  input  wire pra_pkg::dp_cmd_t  cmd,
  output pra_pkg::dp_stat_t      stat,
  output pra_pkg::out_word_t     res
);

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int LW = (CW > 11) ? CW : 11;
  localparam int PC_RST = (pra_pkg::PAGE_COUNT_RESET > MAX_PAGES) ?
                          MAX_PAGES : pra_pkg::PAGE_COUNT_RESET;

  // Page table: free bit and remaining count per page; tail lengths
  logic [CW:0]   mem_q  [MAX_PAGES];
  logic [CW-1:0] tail_q [MAX_PAGES];

  logic [CW-1:0]     pc_r, idx_r, to_r, from_r, total_r, wp_r, wend_r, clr_r;
  pra_pkg::in_word_t item_r;
  logic [CW:0]       rdata_r;
  logic [CW-1:0]     tdata_r;
  pra_pkg::out_word_t res_r;

  logic [CW-1:0] s_c, s_m1, rd_rem, room, r_eff, adv, nn, wval_free;
  logic          rd_free, prev_ok, next_ok;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] cfg_l, cnt_l;
  logic [CW-1:0] cfg_clamp;
  logic [CW:0]   tail_end;

  assign s_c     = CW'(item_r.start_page);
  assign s_m1    = s_c - CW'(1);
  assign rd_free = rdata_r[CW];
  assign rd_rem  = rdata_r[CW-1:0];
  assign cnt_l   = LW'(item_r.count);

  // Run length clipped to the managed pages
  assign room  = pc_r - idx_r;
  assign r_eff = (rd_rem > room) ? room : rd_rem;
  assign adv   = (!rd_free || r_eff == '0) ? CW'(1) : r_eff;
  assign nn    = (rd_rem > (pc_r - s_c)) ? (pc_r - s_c) : rd_rem;

  assign next_ok = (to_r < pc_r) && rd_free && (rd_rem <= (pc_r - to_r));
  assign prev_ok = (s_c != '0) && rd_free && (rd_rem != '0) &&
                   (tdata_r != '0) && (tdata_r <= s_c);

  assign wval_free = total_r - (wp_r - from_r);
  assign tail_end  = {1'b0, from_r} + {1'b0, total_r} - (CW + 1)'(1);

  // Page count write clamp
  assign cfg_l     = LW'(cfg_wdata);
  assign cfg_clamp = (cfg_l == '0) ? CW'(1) :
                     (cfg_l > LW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(cfg_l);

  // Read address select
  always_comb begin
    unique case (cmd.rd_sel)
      pra_pkg::RD_IDX:   rd_addr = idx_r[AW-1:0];
      pra_pkg::RD_START: rd_addr = s_c[AW-1:0];
      pra_pkg::RD_TO:    rd_addr = to_r[AW-1:0];
      pra_pkg::RD_PREV:  rd_addr = s_m1[AW-1:0];
      default:           rd_addr = idx_r[AW-1:0];
    endcase
  end

  // Status to controller
  always_comb begin
    stat.clr_last = (clr_r == CW'(MAX_PAGES - 1));
    stat.is_free  = (item_r.cmd == pra_pkg::CMD_FREE);
    stat.cnt_zero = (item_r.count == '0);
    stat.sp_bad   = (LW'(item_r.start_page) >= LW'(pc_r));
    stat.idx_end  = (idx_r >= pc_r);
    stat.fit      = rd_free && (LW'(r_eff) >= cnt_l);
    stat.f_unused = rd_free || (rd_rem == '0);
    stat.wr_last  = ((wp_r + CW'(1)) == wend_r);
  end

  // Memories: registered read, one write port each
  always_ff @(posedge clk) begin
    rdata_r <= mem_q[rd_addr];
    tdata_r <= tail_q[rd_addr];
    if (cmd.clr_step) begin
      mem_q[clr_r[AW-1:0]] <= (clr_r < pc_r) ? {1'b1, pc_r - clr_r} : '0;
    end else if (cmd.wr_step) begin
      if (stat.is_free) begin
        mem_q[wp_r[AW-1:0]] <= {1'b1, wval_free};
      end else begin
        mem_q[wp_r[AW-1:0]] <= (wp_r == idx_r) ? {1'b0, CW'(item_r.count)} : '0;
      end
    end
    if (cmd.a_take && (LW'(r_eff) > cnt_l)) begin
      tail_q[AW'(idx_r + r_eff - CW'(1))] <= CW'(LW'(r_eff) - cnt_l);
    end else if (cmd.wr_step && stat.wr_last && stat.is_free &&
                 (tail_end < (CW + 1)'(MAX_PAGES))) begin
      tail_q[tail_end[AW-1:0]] <= total_r;
    end
  end

  // Page count and clear pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= CW'(PC_RST);
      clr_r <= '0;
    end else if (cfg_we) begin
      pc_r  <= cfg_clamp;
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + CW'(1);
    end
  end

  // Scan, merge and write pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      idx_r  <= '0;
    end
    if (cmd.a_adv) begin
      idx_r <= idx_r + adv;
    end
    if (cmd.a_take) begin
      wp_r   <= idx_r;
      wend_r <= CW'(LW'(idx_r) + cnt_l);
    end
    if (cmd.f_chk0) begin
      to_r    <= s_c + nn;
      total_r <= nn;
    end
    if (cmd.f_add_next && next_ok) begin
      total_r <= total_r + rd_rem;
    end
    if (cmd.f_prev) begin
      wend_r <= to_r;
      if (prev_ok) begin
        total_r <= total_r + tdata_r;
        from_r  <= s_c - tdata_r;
        wp_r    <= s_c - tdata_r;
      end else begin
        from_r  <= s_c;
        wp_r    <= s_c;
      end
    end
    if (cmd.wr_step) begin
      wp_r <= wp_r + CW'(1);
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_r.status <= cmd.res_status;
      if (cmd.res_status != pra_pkg::ST_OK) begin
        res_r.page       <= '0;
        res_r.run_length <= '0;
      end else if (stat.is_free) begin
        res_r.page       <= 10'(from_r);
        res_r.run_length <= 11'(total_r);
      end else begin
        res_r.page       <= 10'(idx_r);
        res_r.run_length <= item_r.count;
      end
    end
  end

  assign res = res_r;

  // Checks
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_step |-> (wp_r < wend_r))
    else $error("write pointer past run end");
  a_take_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.a_take |-> (idx_r < pc_r))
    else $error("allocation beyond page count");
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_step && cmd.wr_step))
    else $error("clear and run write collide");

endmodule

`default_nettype wire

@@ rtl/pra_ctrl.sv @@
// ----------------------------------------------------------------------------
// pra_ctrl
// Sequencer for clearing, first-fit scan, free with merge, and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              start,
  input  wire pra_pkg::dp_stat_t stat,
  output pra_pkg::dp_cmd_t       cmd,
  output logic                   busy,
  output logic                   out_valid
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_CHK   = 11'b000_0000_0100,
    S_ARD   = 11'b000_0000_1000,
    S_AEV   = 11'b000_0001_0000,
    S_FEV0  = 11'b000_0010_0000,
    S_FRD1  = 11'b000_0100_0000,
    S_FEV1  = 11'b000_1000_0000,
    S_FEV2  = 11'b001_0000_0000,
    S_WR    = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = pra_pkg::RD_IDX;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!stat.is_free) begin
          if (stat.cnt_zero) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = pra_pkg::ST_BAD;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_ARD;
          end
        end else if (stat.sp_bad) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = pra_pkg::ST_BAD;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_sel = pra_pkg::RD_START;
          state_nxt  = S_FEV0;
        end
      end
      S_ARD: begin
        if (stat.idx_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = pra_pkg::ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_AEV;
        end
      end
      S_AEV: begin
        if (stat.fit) begin
          cmd.a_take = 1'b1;
          state_nxt  = S_WR;
        end else begin
          cmd.a_adv = 1'b1;
          state_nxt = S_ARD;
        end
      end
      S_FEV0: begin
        if (stat.f_unused) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = pra_pkg::ST_NOT_USED;
          state_nxt      = S_DONE;
        end else begin
          cmd.f_chk0 = 1'b1;
          state_nxt  = S_FRD1;
        end
      end
      S_FRD1: begin
        cmd.rd_sel = pra_pkg::RD_TO;
        state_nxt  = S_FEV1;
      end
      S_FEV1: begin
        cmd.f_add_next = 1'b1;
        cmd.rd_sel     = pra_pkg::RD_PREV;
        state_nxt      = S_FEV2;
      end
      S_FEV2: begin
        cmd.f_prev = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        cmd.wr_step = 1'b1;
        if (stat.wr_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = pra_pkg::ST_OK;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    // page count write restarts the clearing pass
    if (cfg_we) state_nxt = S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  // Checks
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");
  a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

endmodule

`default_nettype wire

@@ rtl/page_run_allocator_unit.sv @@
// Accept to result strobe: a zero allocate count or a free start page out of range is
// rejected at the check, an unused page after a table read; allocate scans for a fitting
// run and writes it or reports no space; free merges neighbour runs, then rewrites them.
// Throughput: one request at a time; the next is taken the cycle after the strobe.
// Reset and every page count write run a clearing pass over all MAX_PAGES entries, busy high.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
// page_run_allocator_unit
// First-fit page run allocator with free-run merging, top level.
// ----------------------------------------------------------------------------
`default_nettype none

module page_run_allocator_unit #(
  parameter int MAX_PAGES = pra_pkg::MAX_PAGES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [10:0]       cfg_wdata,
  input  wire logic              start,
  input  wire pra_pkg::in_word_t in_data,
  output logic                   busy,
  output logic                   out_valid,
  output pra_pkg::out_word_t     out_data
);

  pra_pkg::dp_cmd_t  cmd;
  pra_pkg::dp_stat_t stat;

  pra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pra_datapath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .res       (out_data)
  );

endmodule

`default_nettype wire
